// File: src/card_reader_reply_parser_defines.svh
// assertion macros used by crrp_parse_core
`ifndef CARD_READER_REPLY_PARSER_DEFINES_SVH
`define CARD_READER_REPLY_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CRRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CRRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CRRP_ASSERT(lbl, prop, msg)

`define CRRP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/crrp_pkg.sv
`default_nettype none

package crrp_pkg;

    localparam int FRAME_BYTES = 256;

    // only store bytes 1..20 are ever read back
    localparam int STORE_FIRST = 1;
    localparam int STORE_LAST  = 20;
    localparam int ID_POS      = 7;
    localparam int BLOCK_POS   = 5;
    localparam int BLOCK_BYTES = 8;

    localparam logic [8:0] LEN_LIMIT = 9'(FRAME_BYTES);

    localparam logic [7:0] SOF_CARD    = 8'h04;
    localparam logic [7:0] SOF_MODE    = 8'h02;
    localparam logic [7:0] LEN_ID      = 8'h0C;
    localparam logic [7:0] LEN_BLOCK   = 8'h16;
    localparam logic [7:0] TYPE_ID     = 8'h02;
    localparam logic [7:0] TYPE_BLOCK  = 8'h03;
    localparam logic [7:0] MODE_CMD    = 8'hB1;
    localparam logic [7:0] MODE_ARG_OK = 8'h02;
    localparam logic [7:0] HEADER_END  = 8'd3;
    localparam logic [7:0] MIN_LEN     = 8'd3;
    localparam logic [7:0] TIMEOUT_RST = 8'd20;

    localparam logic REG_TIMEOUT_RELOAD = 1'b0;
    localparam logic REG_ACCEPT_ENABLE  = 1'b1;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_CSUM_BAD     = 4'd1,
        EV_ID_LATCHED   = 4'd2,
        EV_BLOCK_LATCHED = 4'd3,
        EV_OK_DISABLED  = 4'd4,
        EV_MODE_OK      = 4'd5,
        EV_MODE_REINIT  = 4'd6,
        EV_OTHER_OK     = 4'd7,
        EV_BAD_LEN      = 4'd8
    } event_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] timeout_reload;
        logic       accept_enable;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [31:0] card_id;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } result_t;

endpackage

`default_nettype wire

// File: src/crrp_parse_core.sv
`default_nettype none
`include "card_reader_reply_parser_defines.svh"

module crrp_parse_core
    import crrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_HEADER = 3'd1,
        ST_ID     = 3'd2,
        ST_BLOCK  = 3'd3,
        ST_MODE   = 3'd4
    } state_t;

    state_t      state_reg, state_next, st_eff;
    logic [7:0]  count_reg, count_next, cnt_inc;
    logic [7:0]  timeout_reg, timeout_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  store_reg [STORE_FIRST:STORE_LAST];
    logic [7:0]  store_next [STORE_FIRST:STORE_LAST];
    logic [7:0]  store_view [STORE_FIRST:STORE_LAST];
    logic [31:0] held_id_reg, held_id_next;
    logic [63:0] held_lo_reg, held_lo_next;
    logic [63:0] held_hi_reg, held_hi_next;
    logic [7:0]  len;
    logic        good;
    logic        frame_active;
    event_t      ev;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        timeout_next = timeout_reg;
        xor_next     = xor_reg;
        held_id_next = held_id_reg;
        held_lo_next = held_lo_reg;
        held_hi_next = held_hi_reg;
        ev           = EV_NONE;
        cnt_inc      = count_reg + 8'd1;
        good         = (~xor_reg == item.rx_byte);
        st_eff       = (timeout_reg == 8'd0) ? ST_IDLE : state_reg;
        frame_active = (st_eff == ST_HEADER) || (st_eff == ST_ID) ||
                       (st_eff == ST_BLOCK) || (st_eff == ST_MODE);
        for (int i = STORE_FIRST; i <= STORE_LAST; i++)
        begin
            store_next[i] = store_reg[i];
            store_view[i] = (count_reg == 8'(i)) ? item.rx_byte : store_reg[i];
        end
        len = store_view[1];

        if (item.func)
        begin
            if (timeout_reg != 8'd0)
                timeout_next = timeout_reg - 8'd1;
        end
        else if (!frame_active)
        begin
            state_next = ST_IDLE;
            if (item.rx_byte == SOF_CARD || item.rx_byte == SOF_MODE)
            begin
                state_next   = (item.rx_byte == SOF_CARD) ? ST_HEADER : ST_MODE;
                count_next   = 8'd1;
                xor_next     = item.rx_byte;
                timeout_next = cfg.timeout_reload;
            end
        end
        else
        begin
            for (int i = STORE_FIRST; i <= STORE_LAST; i++)
                store_next[i] = store_view[i];
            xor_next     = xor_reg ^ item.rx_byte;
            count_next   = cnt_inc;
            timeout_next = cfg.timeout_reload;
            unique case (st_eff)
                ST_HEADER:
                begin
                    if (cnt_inc >= HEADER_END)
                    begin
                        if (store_view[1] == LEN_ID && store_view[2] == TYPE_ID)
                            state_next = ST_ID;
                        else if (store_view[1] == LEN_BLOCK && store_view[2] == TYPE_BLOCK)
                            state_next = ST_BLOCK;
                        else
                            state_next = ST_IDLE;
                    end
                end
                ST_ID:
                begin
                    if (cnt_inc >= LEN_ID)
                    begin
                        state_next = ST_IDLE;
                        if (!good)
                            ev = EV_CSUM_BAD;
                        else if (cfg.accept_enable)
                        begin
                            held_id_next = {store_view[ID_POS], store_view[ID_POS + 1],
                                            store_view[ID_POS + 2], store_view[ID_POS + 3]};
                            ev = EV_ID_LATCHED;
                        end
                        else
                            ev = EV_OK_DISABLED;
                    end
                end
                ST_BLOCK:
                begin
                    if (cnt_inc >= LEN_BLOCK)
                    begin
                        state_next = ST_IDLE;
                        if (!good)
                            ev = EV_CSUM_BAD;
                        else if (cfg.accept_enable)
                        begin
                            for (int k = 0; k < BLOCK_BYTES; k++)
                            begin
                                held_lo_next[8*k +: 8] = store_view[BLOCK_POS + k];
                                held_hi_next[8*k +: 8] =
                                    store_view[BLOCK_POS + BLOCK_BYTES + k];
                            end
                            ev = EV_BLOCK_LATCHED;
                        end
                        else
                            ev = EV_OK_DISABLED;
                    end
                end
                default:
                begin
                    // mode reply, length taken from byte 1
                    if (cnt_inc == 8'd2 && (len < MIN_LEN || {1'b0, len} > LEN_LIMIT))
                    begin
                        state_next = ST_IDLE;
                        ev         = EV_BAD_LEN;
                    end
                    else if (cnt_inc >= MIN_LEN && cnt_inc >= len)
                    begin
                        state_next = ST_IDLE;
                        if (!good)
                            ev = EV_CSUM_BAD;
                        else if (store_view[2] == MODE_CMD)
                            ev = (store_view[5] != MODE_ARG_OK || store_view[7] != 8'd0) ?
                                 EV_MODE_REINIT : EV_MODE_OK;
                        else
                            ev = EV_OTHER_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= 8'd0;
            timeout_reg <= 8'd0;
            xor_reg     <= 8'd0;
            held_id_reg <= 32'd0;
            held_lo_reg <= 64'd0;
            held_hi_reg <= 64'd0;
            for (int i = STORE_FIRST; i <= STORE_LAST; i++)
                store_reg[i] <= 8'd0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            timeout_reg <= timeout_next;
            xor_reg     <= xor_next;
            held_id_reg <= held_id_next;
            held_lo_reg <= held_lo_next;
            held_hi_reg <= held_hi_next;
            for (int i = STORE_FIRST; i <= STORE_LAST; i++)
                store_reg[i] <= store_next[i];
        end
    end

    assign result.event_res  = ev;
    assign result.card_id    = held_id_next;
    assign result.block_low  = held_lo_next;
    assign result.block_high = held_hi_next;

    `CRRP_ASSERT_NEXT(a_tick_no_rise, step && item.func,
        timeout_reg <= $past(timeout_reg), "timeout rose on a tick")
    `CRRP_ASSERT(a_count_live, (state_reg != ST_IDLE) |-> (count_reg != 8'd0),
        "open frame with zero byte count")
    `CRRP_ASSERT_NEXT(a_event_idle, step && ev != EV_NONE,
        state_reg == ST_IDLE, "frame event left parser busy")
    `CRRP_ASSERT_NEXT(a_id_hold, !(step && ev == EV_ID_LATCHED),
        $stable(held_id_reg), "card id changed without id event")

endmodule

`default_nettype wire

// File: src/crrp_result_reg.sv
`default_nettype none

module crrp_result_reg
    import crrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t d,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t q
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= d;
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

// File: src/card_reader_reply_parser.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    func, rx_byte
// result    out        out_valid / out_ready  event_res, card_id, block_low, block_high
// config    in         cfg_wr_en              cfg_index, cfg_wdata
//
// one result per transaction, one transaction per cycle sustained while out_ready stays high
// each transaction passes the input register, then parse logic into the result register
// in_ready drops only while both the input and result registers hold a transaction
// and out_ready is low
// reset clears parser state, frame bytes, held data, accept_enable and loads timeout_reload 20
`default_nettype none

module card_reader_reply_parser
    import crrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_res,
    output logic [31:0] card_id,
    output logic [63:0] block_low,
    output logic [63:0] block_high,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic    in_valid_reg;
    item_t   item_reg;
    cfg_t    cfg_reg;
    logic    advance;
    result_t core_res;
    result_t res_q;

    assign advance  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            cfg_reg.timeout_reload <= TIMEOUT_RST;
            cfg_reg.accept_enable  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_TIMEOUT_RELOAD: cfg_reg.timeout_reload <= cfg_wdata;
                    REG_ACCEPT_ENABLE:  cfg_reg.accept_enable  <= cfg_wdata[0];
                    default:            cfg_reg.accept_enable  <= cfg_reg.accept_enable;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.func    <= func;
            item_reg.rx_byte <= rx_byte;
        end
    end

    crrp_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (core_res)
    );

    crrp_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .d         (core_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .q         (res_q)
    );

    assign event_res  = res_q.event_res;
    assign card_id    = res_q.card_id;
    assign block_low  = res_q.block_low;
    assign block_high = res_q.block_high;

endmodule

`default_nettype wire

// File: bench/crrp_reply_monitor.sv
module crrp_reply_monitor
    import crrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  event_res,
    input  logic [31:0] card_id,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          frames_closed
);

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_HEADER,
        PS_ID_FRAME,
        PS_BLOCK_FRAME,
        PS_MODE_REPLY
    } parse_state_t;

    parse_state_t state_q;
    logic [7:0]   count_q;
    logic [7:0]   timer_q;
    logic [7:0]   xor_q;
    logic [7:0]   reload_q;
    logic         accept_q;
    logic [7:0]   frame_mem [0:FRAME_BYTES-1];
    logic [31:0]  id_q;
    logic [63:0]  blk_lo_q;
    logic [63:0]  blk_hi_q;
    result_t      expected_replies[$];

    function automatic event_t parse_reply_item(input logic is_tick, input logic [7:0] b);
        event_t     ev;
        logic       good;
        logic [7:0] len;
        ev = EV_NONE;
        if (is_tick)
        begin
            if (timer_q != 8'd0)
                timer_q = timer_q - 8'd1;
            return ev;
        end
        // an expired timeout drops any partial frame first
        if (timer_q == 8'd0)
            state_q = PS_IDLE;
        if (state_q == PS_IDLE)
        begin
            if (b == SOF_CARD || b == SOF_MODE)
            begin
                frame_mem[0] = b;
                count_q      = 8'd1;
                xor_q        = b;
                timer_q      = reload_q;
                if (b == SOF_CARD)
                    state_q = PS_HEADER;
                else
                    state_q = PS_MODE_REPLY;
            end
            return ev;
        end
        frame_mem[count_q] = b;
        good    = (~xor_q == b);
        xor_q   = xor_q ^ b;
        count_q = count_q + 8'd1;
        timer_q = reload_q;
        case (state_q)
            PS_HEADER:
            begin
                if (count_q >= HEADER_END)
                begin
                    if (frame_mem[1] == LEN_ID && frame_mem[2] == TYPE_ID)
                        state_q = PS_ID_FRAME;
                    else if (frame_mem[1] == LEN_BLOCK && frame_mem[2] == TYPE_BLOCK)
                        state_q = PS_BLOCK_FRAME;
                    else
                        state_q = PS_IDLE;
                end
            end
            PS_ID_FRAME:
            begin
                if (count_q >= LEN_ID)
                begin
                    state_q = PS_IDLE;
                    if (!good)
                        ev = EV_CSUM_BAD;
                    else if (accept_q)
                    begin
                        id_q = {frame_mem[ID_POS], frame_mem[ID_POS + 1],
                                frame_mem[ID_POS + 2], frame_mem[ID_POS + 3]};
                        ev = EV_ID_LATCHED;
                    end
                    else
                        ev = EV_OK_DISABLED;
                end
            end
            PS_BLOCK_FRAME:
            begin
                if (count_q >= LEN_BLOCK)
                begin
                    state_q = PS_IDLE;
                    if (!good)
                        ev = EV_CSUM_BAD;
                    else if (accept_q)
                    begin
                        for (int k = 0; k < BLOCK_BYTES; k++)
                        begin
                            blk_lo_q[8*k +: 8] = frame_mem[BLOCK_POS + k];
                            blk_hi_q[8*k +: 8] = frame_mem[BLOCK_POS + BLOCK_BYTES + k];
                        end
                        ev = EV_BLOCK_LATCHED;
                    end
                    else
                        ev = EV_OK_DISABLED;
                end
            end
            default:
            begin
                len = frame_mem[1];
                if (count_q == 8'd2 && len < MIN_LEN)
                begin
                    state_q = PS_IDLE;
                    ev      = EV_BAD_LEN;
                end
                else if (count_q >= 8'd3 && count_q >= len)
                begin
                    state_q = PS_IDLE;
                    if (!good)
                        ev = EV_CSUM_BAD;
                    else if (frame_mem[2] == MODE_CMD)
                    begin
                        // short replies read stale bytes 5 and 7
                        if (frame_mem[5] != MODE_ARG_OK || frame_mem[7] != 8'h00)
                            ev = EV_MODE_REINIT;
                        else
                            ev = EV_MODE_OK;
                    end
                    else
                        ev = EV_OTHER_OK;
                end
            end
        endcase
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        event_t  ev;
        if (!rst_n)
        begin
            state_q  = PS_IDLE;
            count_q  = 8'd0;
            timer_q  = 8'd0;
            xor_q    = 8'd0;
            reload_q = TIMEOUT_RST;
            accept_q = 1'b0;
            id_q     = 32'd0;
            blk_lo_q = 64'd0;
            blk_hi_q = 64'd0;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_mem[i] = 8'h00;
            expected_replies.delete();
            fail_count      = 0;
            outstanding     = 0;
            results_checked = 0;
            frames_closed   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: event %0d id %h low %h high %h",
                                 event_res, card_id, block_low, block_high);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    results_checked++;
                    if (event_res !== want.event_res || card_id !== want.card_id ||
                        block_low !== want.block_low || block_high !== want.block_high)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display(
                                "mismatch exp/act: event %0d/%0d id %h/%h lo %h/%h hi %h/%h",
                                want.event_res, event_res, want.card_id, card_id,
                                want.block_low, block_low, want.block_high, block_high);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_TIMEOUT_RELOAD)
                    reload_q = cfg_wdata;
                else
                    accept_q = cfg_wdata[0];
            end
            if (in_valid && in_ready)
            begin
                ev = parse_reply_item(func, rx_byte);
                if (ev != EV_NONE)
                    frames_closed++;
                want.event_res  = ev;
                want.card_id    = id_q;
                want.block_low  = blk_lo_q;
                want.block_high = blk_hi_q;
                expected_replies.push_back(want);
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

// File: bench/tb_card_reader_reply_parser.sv
module tb_card_reader_reply_parser;
    import crrp_pkg::*;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        func       = 1'b0;
    logic [7:0]  rx_byte    = 8'h00;
    logic        out_ready  = 1'b0;
    logic        cfg_wr_en  = 1'b0;
    logic        cfg_index  = 1'b0;
    logic [7:0]  cfg_wdata  = 8'h00;
    logic        in_ready;
    logic        out_valid;
    logic [3:0]  event_res;
    logic [31:0] card_id;
    logic [63:0] block_low;
    logic [63:0] block_high;

    int fail_count;
    int outstanding;
    int results_checked;
    int frames_closed;

    int         items_sent    = 0;
    int         ticks_sent    = 0;
    int         settings_used = 0;
    logic       idling_on     = 1'b1;
    logic [7:0] reload_now    = TIMEOUT_RST;
    logic [7:0] reply_bytes[$];

    card_reader_reply_parser dut (.*);

    crrp_reply_monitor reply_monitor (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= !(idling_on && $urandom_range(0, 99) < 10);

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input logic is_tick, input logic [7:0] value);
        while (idling_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= is_tick;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (is_tick)
            ticks_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_reply_bytes();
        foreach (reply_bytes[i])
        begin
            send_item(1'b0, reply_bytes[i]);
            if ($urandom_range(0, 99) < 6)
                send_ticks($urandom_range(1, 3));
        end
    endtask

    task automatic append_checksum(input logic bad_sum);
        logic [7:0] sum;
        sum = 8'h00;
        foreach (reply_bytes[i])
            sum = sum ^ reply_bytes[i];
        sum = ~sum;
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        reply_bytes.push_back(sum);
    endtask

    task automatic queue_card_frame(input logic is_block, input logic bad_sum);
        int n;
        n = int'(is_block ? LEN_BLOCK : LEN_ID);
        reply_bytes.delete();
        reply_bytes.push_back(SOF_CARD);
        reply_bytes.push_back(is_block ? LEN_BLOCK : LEN_ID);
        reply_bytes.push_back(is_block ? TYPE_BLOCK : TYPE_ID);
        while (reply_bytes.size() < n - 1)
            reply_bytes.push_back(8'($urandom_range(0, 255)));
        append_checksum(bad_sum);
    endtask

    // a length below three ends the reply at the length byte
    task automatic queue_mode_reply(input logic [7:0] len, input logic [7:0] cmd,
                                    input logic bad_sum);
        reply_bytes.delete();
        reply_bytes.push_back(SOF_MODE);
        reply_bytes.push_back(len);
        if (len >= MIN_LEN)
        begin
            if (len > MIN_LEN)
                reply_bytes.push_back(cmd);
            while (reply_bytes.size() < int'(len) - 1)
            begin
                if (reply_bytes.size() == 5 && $urandom_range(0, 9) < 7)
                    reply_bytes.push_back(MODE_ARG_OK);
                else if (reply_bytes.size() == 7 && $urandom_range(0, 9) < 7)
                    reply_bytes.push_back(8'h00);
                else
                    reply_bytes.push_back(8'($urandom_range(0, 255)));
            end
            append_checksum(bad_sum);
        end
    endtask

    task automatic random_sequence();
        int         pick;
        int         roll;
        int         cut;
        logic [7:0] len;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (roll < 8)
            len = 8'($urandom_range(0, 2));
        else if (roll < 16)
            len = 8'($urandom_range(13, 60));
        else if (roll < 17)
            len = 8'($urandom_range(200, 255));
        else
            len = 8'($urandom_range(3, 12));
        cmd = ($urandom_range(0, 9) < 6) ? MODE_CMD : 8'($urandom_range(0, 255));
        if (pick < 30)
            queue_card_frame(1'b0, $urandom_range(0, 99) < 15);
        else if (pick < 50)
            queue_card_frame(1'b1, $urandom_range(0, 99) < 15);
        else if (pick < 75)
            queue_mode_reply(len, cmd, $urandom_range(0, 99) < 15);
        else if (pick < 83)
        begin
            reply_bytes.delete();
            reply_bytes.push_back(SOF_CARD);
            reply_bytes.push_back(($urandom_range(0, 1) == 0) ? LEN_ID
                                                              : 8'($urandom_range(0, 255)));
            reply_bytes.push_back(($urandom_range(0, 1) == 0) ? TYPE_BLOCK
                                                              : 8'($urandom_range(0, 255)));
        end
        else if (pick < 91)
        begin
            // truncated frame, the next transactions land inside it
            if ($urandom_range(0, 2) == 0)
                queue_mode_reply(len, cmd, 1'b0);
            else
                queue_card_frame(1'($urandom_range(0, 1)), 1'b0);
            if (reply_bytes.size() > 1)
            begin
                cut = $urandom_range(1, reply_bytes.size() - 1);
                repeat (cut) void'(reply_bytes.pop_back());
            end
        end
        else
        begin
            reply_bytes.delete();
            repeat ($urandom_range(1, 4))
                reply_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 3)
            send_ticks($urandom_range(0, int'(reload_now) + 1));
        send_reply_bytes();
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] reload, input logic enable);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TIMEOUT_RELOAD;
        cfg_wdata <= reload;
        @(posedge clk);
        cfg_index <= REG_ACCEPT_ENABLE;
        cfg_wdata <= {7'd0, enable};
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        reload_now = reload;
        settings_used++;
    endtask

    task automatic run_phase(input logic [7:0] reload, input logic enable, input logic quiet,
                             input int count);
        int target;
        drain_replies();
        apply_settings(reload, enable);
        idling_on <= !quiet;
        target = items_sent + count;
        while (items_sent < target)
            random_sequence();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick with the timeout already at zero, stray bytes in idle
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        // good id frame while accept is off
        queue_card_frame(1'b0, 1'b0);
        send_reply_bytes();
        // mode reply with a length that is too short
        queue_mode_reply(8'd1, MODE_CMD, 1'b0);
        send_reply_bytes();
        // header with the id length and the block type
        reply_bytes = '{SOF_CARD, LEN_ID, TYPE_BLOCK};
        send_reply_bytes();
        // shortest mode reply, the checksum sits where the command would be
        queue_mode_reply(MIN_LEN, MODE_CMD, 1'b0);
        send_reply_bytes();

        run_phase(8'd255, 1'b1, 1'b1, 250);
        run_phase(TIMEOUT_RST, 1'b1, 1'b0, 250);
        run_phase(8'd1, 1'b1, 1'b0, 250);
        run_phase(8'd0, 1'b1, 1'b0, 150);
        run_phase(8'd3, 1'b0, 1'b0, 250);
        run_phase(8'($urandom_range(1, 255)), 1'b1, 1'b0, 250);
        run_phase(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 250);
        run_phase(TIMEOUT_RST, 1'b1, 1'b0, 350);
        drain_replies();

        $display("summary: %0d transactions sent (%0d ticks) over %0d register settings",
                 items_sent, ticks_sent, settings_used);
        $display("summary: %0d results checked, %0d frames closed with an event, %0d errors",
                 results_checked, frames_closed, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
